// ===== design/aiks_pkg.sv =====
// ----------------------------------------------------------------------------
// AES-128 inverse key schedule package
// Beat types, the AES S-box and the round constants shared by the pipeline.
// ----------------------------------------------------------------------------
package aiks_pkg;

  // Input beat: round key, byte 0 in the top bits of round_key_high.
  typedef struct packed {
    logic [63:0] round_key_high;
    logic [63:0] round_key_low;
  } round_key_t;

  // Output beat: recovered cipher key, same byte order.
  typedef struct packed {
    logic [63:0] cipher_key_high;
    logic [63:0] cipher_key_low;
  } cipher_key_t;

  localparam int unsigned KeyW   = 128;
  localparam int unsigned CountW = 4;

  typedef logic [KeyW-1:0]   key_t;
  typedef logic [CountW-1:0] count_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  function automatic logic [7:0] sbox(input logic [7:0] b);
    return SBOX[b];
  endfunction

  // Round constant used when building the key of round rnd.
  function automatic logic [7:0] rcon(input count_t rnd);
    logic [7:0] r;
    unique case (rnd)
      4'd1:    r = 8'h01;
      4'd2:    r = 8'h02;
      4'd3:    r = 8'h04;
      4'd4:    r = 8'h08;
      4'd5:    r = 8'h10;
      4'd6:    r = 8'h20;
      4'd7:    r = 8'h40;
      4'd8:    r = 8'h80;
      4'd9:    r = 8'h1b;
      4'd10:   r = 8'h36;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  // Turns the round key of round rnd into the key of round rnd-1.
  function automatic key_t undo_round(input key_t k, input count_t rnd);
    logic [31:0] w0, w1, w2, w3, p0, p1, p2, p3, t;
    w0 = k[127:96];
    w1 = k[95:64];
    w2 = k[63:32];
    w3 = k[31:0];
    p1 = w1 ^ w0;
    p2 = w2 ^ w1;
    p3 = w3 ^ w2;
    t  = {sbox(p3[23:16]), sbox(p3[15:8]), sbox(p3[7:0]), sbox(p3[31:24])};
    p0 = w0 ^ t ^ {rcon(rnd), 24'h000000};
    return {p0, p1, p2, p3};
  endfunction

endpackage

// ===== design/aiks_stage.sv =====
// ----------------------------------------------------------------------------
// AES-128 inverse key schedule pipeline stage
// Undoes one fixed round when the beat's count reaches it, then registers.
// ----------------------------------------------------------------------------
module aiks_stage import aiks_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  count_t round_i,
  input  logic   valid_i,
  output logic   ready_o,
  input  key_t   key_i,
  input  count_t count_i,
  output logic   valid_o,
  input  logic   ready_i,
  output key_t   key_o,
  output count_t count_o
);

  logic   valid_q;
  key_t   key_q, key_d;
  count_t count_q;

  // The slot may load when it is empty or its beat leaves this cycle.
  assign ready_o = !valid_q || ready_i;

  always_comb begin
    if (count_i >= round_i) begin
      key_d = undo_round(key_i, round_i);
    end else begin
      key_d = key_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      key_q   <= key_d;
      count_q <= count_i;
    end
  end

  assign valid_o = valid_q;
  assign key_o   = key_q;
  assign count_o = count_q;

endmodule

// ===== design/aes128_inverse_key_schedule_unit.sv =====
// ----------------------------------------------------------------------------
// AES-128 inverse key schedule unit
// Recovers the AES-128 cipher key from the round key of a configured round.
// ----------------------------------------------------------------------------
// The unit takes the round key of round N on the input channel and returns
// the original cipher key on the output channel, one result beat for each
// input beat, in order. N comes from the round_count register, which the user
// writes through cfg_we_i/cfg_wdata_i only while the unit is idle; the unit
// does not enforce this. It resets to 4, a value of zero returns the key
// unchanged and values above MAX_ROUNDS act as MAX_ROUNDS. The datapath is a
// pipeline of MAX_ROUNDS registered stages, one per key schedule round, so a
// beat is accepted every cycle while the output side does not stall; its
// result passes through every stage register in order. Each stage's logic is
// a single inverse round (word XORs, four S-box lookups and the round
// constant), which sets the clock rate. Every stage holds its beat while the
// next one cannot take it, so back pressure on the output never loses or
// repeats a beat; the ready path runs combinationally through all stages.
// ----------------------------------------------------------------------------
module aes128_inverse_key_schedule_unit import aiks_pkg::*; #(
  parameter int unsigned MAX_ROUNDS = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  round_key_t  in_beat_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output cipher_key_t out_beat_o
);

  localparam count_t MaxCount = CountW'(MAX_ROUNDS);

  count_t round_count_q;
  count_t count_sat;

  // Links between stages: entry 0 is the input port, the last is the output.
  logic   link_valid [MAX_ROUNDS+1];
  logic   link_ready [MAX_ROUNDS+1];
  key_t   link_key   [MAX_ROUNDS+1];
  count_t link_count [MAX_ROUNDS+1];

  // The configuration register is written with no handshake.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      round_count_q <= 4'd4;
    end else if (cfg_we_i) begin
      round_count_q <= cfg_wdata_i;
    end
  end

  // Counts above the number of stages run every stage.
  assign count_sat = (round_count_q > MaxCount) ? MaxCount : round_count_q;

  assign link_valid[0] = in_valid_i;
  assign in_ready_o    = link_ready[0];
  assign link_key[0]   = {in_beat_i.round_key_high, in_beat_i.round_key_low};
  assign link_count[0] = count_sat;

  // Stage s undoes round MAX_ROUNDS - s, so the highest round goes first and
  // round 1 is undone by the last stage, just as the schedule is walked back.
  for (genvar s = 0; s < MAX_ROUNDS; s++) begin : g_stage
    aiks_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .round_i (CountW'(MAX_ROUNDS - s)),
      .valid_i (link_valid[s]),
      .ready_o (link_ready[s]),
      .key_i   (link_key[s]),
      .count_i (link_count[s]),
      .valid_o (link_valid[s+1]),
      .ready_i (link_ready[s+1]),
      .key_o   (link_key[s+1]),
      .count_o (link_count[s+1])
    );
  end

  // The last stage register is the output register.
  assign out_valid_o                = link_valid[MAX_ROUNDS];
  assign link_ready[MAX_ROUNDS]     = out_ready_i;
  assign out_beat_o.cipher_key_high = link_key[MAX_ROUNDS][127:64];
  assign out_beat_o.cipher_key_low  = link_key[MAX_ROUNDS][63:0];

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// AES-128 inverse key schedule unit testbench
// Sends round keys through the valid/ready input channel under a series of
// round_count settings. Each result beat is checked against a key recovered
// by an independent model that builds its own S-box and round constants.
// ----------------------------------------------------------------------------
module tb import aiks_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_ROUNDS  = 10;
  localparam int unsigned CYCLE_LIMIT = 400000;

  // round_count settings, one per phase after the reset phase. Zero (key
  // returned unchanged), the full ten rounds and the saturating values above
  // ten all appear, along with every other count.
  localparam count_t PHASE_ROUNDS [16] = '{
    4'd0, 4'd10, 4'd15, 4'd1, 4'd11, 4'd2, 4'd3, 4'd5,
    4'd6, 4'd7, 4'd8, 4'd9, 4'd12, 4'd13, 4'd14, 4'd4
  };

  // Directed keys: all zeros, all ones, the two checkerboards, and the
  // published AES-128 example key together with its round ten key.
  localparam round_key_t KNOWN_KEYS [6] = '{
    128'h0000_0000_0000_0000_0000_0000_0000_0000,
    128'hffff_ffff_ffff_ffff_ffff_ffff_ffff_ffff,
    128'h5555_5555_5555_5555_5555_5555_5555_5555,
    128'haaaa_aaaa_aaaa_aaaa_aaaa_aaaa_aaaa_aaaa,
    128'h2b7e_1516_28ae_d2a6_abf7_1588_09cf_4f3c,
    128'hd014_f9a8_c9ee_2589_e13f_0cc8_b663_0ca6
  };

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  count_t      cfg_wdata_i = '0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  round_key_t  in_beat_i   = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  cipher_key_t out_beat_o;

  // Model state: the S-box and round constants derived from first
  // principles, and our copy of the round_count register.
  logic [7:0]  sub_byte [256];
  logic [7:0]  round_const [1:MAX_ROUNDS];
  count_t      key_rounds = 4'd4;

  round_key_t  pending_keys [$];   // round keys waiting to be driven
  cipher_key_t expected_keys [$];  // recovered keys, oldest first
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  logic        in_took = 1'b0;     // an input beat moved at the last rising edge

  aes128_inverse_key_schedule_unit #(
    .MAX_ROUNDS(MAX_ROUNDS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_beat_i  (in_beat_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_beat_o (out_beat_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Walks the key schedule backwards from the given round to round zero.
  // Words 1 to 3 of the earlier key are the XOR of neighbouring words; the
  // update runs from word 3 down so each XOR still sees the current word.
  // Word 0 then folds in SubWord(RotWord(new word 3)) and the round constant.
  // Counts above MAX_ROUNDS saturate, and a count of zero runs no step.
  function automatic cipher_key_t recover_cipher_key(input round_key_t rk,
                                                     input count_t cnt);
    logic [31:0] w [4];
    logic [31:0] rot;
    int          steps;
    steps = (cnt > MAX_ROUNDS) ? MAX_ROUNDS : int'(cnt);
    {w[0], w[1]} = rk.round_key_high;
    {w[2], w[3]} = rk.round_key_low;
    for (int r = steps; r >= 1; r--) begin
      w[3] = w[3] ^ w[2];
      w[2] = w[2] ^ w[1];
      w[1] = w[1] ^ w[0];
      rot  = {w[3][23:0], w[3][31:24]};
      w[0] = w[0] ^ {sub_byte[rot[31:24]] ^ round_const[r], sub_byte[rot[23:16]],
                     sub_byte[rot[15:8]], sub_byte[rot[7:0]]};
    end
    return '{cipher_key_high: {w[0], w[1]}, cipher_key_low: {w[2], w[3]}};
  endfunction

  // Every mismatch goes through here so that the final verdict sees it.
  task automatic note_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Monitor: sampled at the rising edge, where every input of the unit was
  // set up at the falling edge before it and its registered outputs still hold
  // their values from before the edge. An accepted input beat is turned into its
  // expected key right away, with the round count in force at that moment.
  always @(posedge clk_i) begin
    cipher_key_t want;
    cycle_count <= cycle_count + 1;
    in_took     <= rst_ni && in_valid_i && in_ready_o;
    if (rst_ni) begin
      if (cfg_we_i) begin
        key_rounds <= cfg_wdata_i;
      end
      if (in_valid_i && in_ready_o) begin
        expected_keys = {expected_keys, recover_cipher_key(in_beat_i, key_rounds)};
      end
      if (out_valid_o && out_ready_i) begin
        if (expected_keys.size() == 0) begin
          note_mismatch($sformatf("result beat %h with nothing outstanding", out_beat_o));
        end else begin
          want = expected_keys.pop_front();
          if (out_beat_o.cipher_key_high !== want.cipher_key_high) begin
            note_mismatch($sformatf("cipher_key_high %h, expected %h",
                                    out_beat_o.cipher_key_high, want.cipher_key_high));
          end
          if (out_beat_o.cipher_key_low !== want.cipher_key_low) begin
            note_mismatch($sformatf("cipher_key_low %h, expected %h",
                                    out_beat_o.cipher_key_low, want.cipher_key_low));
          end
        end
      end
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk_i) begin
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Input driver: moves on at the falling edge. A beat on the wire stays put
  // until it has been accepted. The sender works in bursts of random length;
  // before each burst it may sit out a random gap, and about a quarter of the
  // bursts start with no gap at all so back-to-back traffic is covered too.
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_took) begin
      if (burst_left == 0 && pending_keys.size() != 0) begin
        burst_left = $urandom_range(1, 48);
        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      end
      if (gap_left != 0 || pending_keys.size() == 0) begin
        in_valid_i <= 1'b0;
        if (gap_left != 0) begin
          gap_left--;
        end
      end else begin
        in_valid_i <= 1'b1;
        in_beat_i  <= pending_keys.pop_front();
        burst_left--;
      end
    end
  end

  // Output side: alternates runs of ready and stall. Ready runs are often long
  // enough to let the pipeline drain at full rate; stalls are mostly short,
  // now and then long enough to back the whole pipeline up to the input.
  logic        ready_run = 1'b0;
  int unsigned hold_left = 0;

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (hold_left == 0) begin
        ready_run = !ready_run;
        if (ready_run) begin
          hold_left = $urandom_range(1, 60);
        end else begin
          hold_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                                  : $urandom_range(1, 4);
        end
      end
      out_ready_i <= ready_run;
      hold_left--;
    end
  end

  // Stimulus sequence. Each phase runs under one round_count value; between
  // phases the sender pauses until every expected key has come back, waits
  // out the pipeline depth, and only then rewrites the register.
  initial begin
    logic [7:0] inv, a, p, rc;
    logic [31:0] w [4];
    int unsigned n_rand;

    // S-box: multiplicative inverse in GF(2^8) as x^254, then the affine map.
    for (int x = 0; x < 256; x++) begin
      inv = 8'h01;
      for (int k = 0; k < 254; k++) begin
        a = inv;
        p = 8'h00;
        for (int i = 0; i < 8; i++) begin
          if (x[i]) begin
            p = p ^ a;
          end
          a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
        end
        inv = p;
      end
      sub_byte[x] = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^
                    {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ 8'h63;
    end
    // Round constants are successive doublings in the same field.
    rc = 8'h01;
    for (int r = 1; r <= MAX_ROUNDS; r++) begin
      round_const[r] = rc;
      rc = {rc[6:0], 1'b0} ^ (rc[7] ? 8'h1b : 8'h00);
    end

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Phase zero keeps the reset value of round_count.
    for (int ph = 0; ph <= 16; ph++) begin
      if (ph != 0) begin
        while (pending_keys.size() != 0 || in_valid_i || expected_keys.size() != 0) begin
          @(negedge clk_i);
        end
        repeat (MAX_ROUNDS + 2) @(negedge clk_i);
        cfg_we_i    <= 1'b1;
        cfg_wdata_i <= PHASE_ROUNDS[ph-1];
        @(negedge clk_i);
        cfg_we_i    <= 1'b0;
      end
      // The directed keys run under the reset count, zero, ten and fifteen.
      if (ph <= 3) begin
        foreach (KNOWN_KEYS[i]) begin
          pending_keys = {pending_keys, KNOWN_KEYS[i]};
        end
      end
      // Random keys; a word is sometimes forced to all zeros or all ones so
      // that the S-box sees its extreme inputs at every round.
      n_rand = $urandom_range(90, 110);
      repeat (n_rand) begin
        foreach (w[i]) begin
          case ($urandom_range(0, 15))
            0:       w[i] = 32'h0000_0000;
            1:       w[i] = 32'hffff_ffff;
            default: w[i] = $urandom;
          endcase
        end
        pending_keys = {pending_keys, round_key_t'({w[0], w[1], w[2], w[3]})};
      end
    end

    while (pending_keys.size() != 0 || in_valid_i || expected_keys.size() != 0) begin
      @(negedge clk_i);
    end
    // Any stray beat the unit still emits shows up as an unexpected result.
    repeat (2 * MAX_ROUNDS + 40) @(negedge clk_i);

    if (mismatch_count == 0 && expected_keys.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
